// File: rtl/ccpd_pkg.sv
package ccpd_pkg;

    // Frame identifiers, low 12 bits
    localparam logic [11:0] ID_SIGNAL = 12'h181;
    localparam logic [11:0] ID_LEFT   = 12'h633;
    localparam logic [11:0] ID_RIGHT  = 12'h634;

    // Seen-mask bits
    localparam logic [2:0] MASK_SIGNAL = 3'b001;
    localparam logic [2:0] MASK_LEFT   = 3'b010;
    localparam logic [2:0] MASK_RIGHT  = 3'b100;
    localparam logic [2:0] MASK_ALL    = 3'b111;

    // Direction pair codes
    localparam logic [1:0] PAIR_IDLE = 2'b00;
    localparam logic [1:0] PAIR_SET  = 2'b01;

    // Stream word widths
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        GEAR_NEUTRAL = 2'd0,
        GEAR_DRIVE   = 2'd1,
        GEAR_REVERSE = 2'd2
    } gear_t;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_NEG  = 2'd1,
        SIGN_POS  = 2'd2
    } sign_t;

    // One received frame plus host flags
    typedef struct packed {
        logic [11:0]     frame_id;
        logic [5:0][7:0] data;
        logic            in_process;
        logic            last_in_batch;
    } frame_t;

    // Held command state
    typedef struct packed {
        logic [2:0]  seen_mask;
        logic [10:0] steer;
        logic [10:0] arm;
        logic [10:0] bucket;
        logic [7:0]  throttle;
        logic [7:0]  brake;
        gear_t       gear;
        logic        front_light;
        logic        back_light;
        logic        wiper;
        logic        emergency_stop;
        logic        resume_request;
    } hold_t;

    // Emitted command record
    typedef struct packed {
        logic [10:0] steer;
        logic [10:0] arm;
        logic [10:0] bucket;
        logic [7:0]  throttle;
        logic [7:0]  brake;
        gear_t       gear;
        logic        front_light;
        logic        back_light;
        logic        wiper;
        logic        emergency_stop;
        logic        resume_request;
    } result_t;

    typedef struct packed {
        logic  ok;
        sign_t sign;
    } dir_check_t;

    // 10-bit magnitude times direction, as 11-bit two's complement
    function automatic logic [10:0] apply_sign(logic [9:0] mag, sign_t sign);
        logic [10:0] wide;
        wide = {1'b0, mag};
        case (sign)
            SIGN_POS: apply_sign = wide;
            SIGN_NEG: apply_sign = 11'd0 - wide;
            default:  apply_sign = 11'd0;
        endcase
    endfunction

    function automatic logic pair_ok(logic [1:0] pair);
        pair_ok = (pair == PAIR_IDLE) || (pair == PAIR_SET);
    endfunction

    // Direction from pair 3:2, else pair 5:4; keep prev when both idle
    function automatic dir_check_t stick_dir(logic [7:0] b, sign_t prev);
        dir_check_t res;
        res.ok   = 1'b1;
        res.sign = prev;
        if (b[3:2] != PAIR_IDLE) begin
            res.ok   = (b[3:2] == PAIR_SET);
            res.sign = SIGN_NEG;
        end else if (b[5:4] != PAIR_IDLE) begin
            res.ok   = (b[5:4] == PAIR_SET);
            res.sign = SIGN_POS;
        end
        stick_dir = res;
    endfunction

endpackage

// File: rtl/ccpd_in_stage.sv
module ccpd_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_id[11:0], byte0..byte5 [59:12], zero pad [63:60]
    input  logic [ccpd_pkg::S_DATA_W-1:0]   s_tdata,
    // in_process
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            advance,
    output logic                            frame_valid,
    output ccpd_pkg::frame_t                frame
);
    import ccpd_pkg::*;

    logic   in_valid_reg;
    logic   in_valid_next;
    frame_t frame_reg;
    frame_t frame_next;
    logic   take;

    // Accept a word when empty or when the held word moves on
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    // Unpack the incoming word
    always_comb begin
        frame_next.frame_id      = s_tdata[11:0];
        frame_next.data[0]       = s_tdata[19:12];
        frame_next.data[1]       = s_tdata[27:20];
        frame_next.data[2]       = s_tdata[35:28];
        frame_next.data[3]       = s_tdata[43:36];
        frame_next.data[4]       = s_tdata[51:44];
        frame_next.data[5]       = s_tdata[59:52];
        frame_next.in_process    = s_tuser;
        frame_next.last_in_batch = s_tlast;
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the payload until it advances
    always_ff @(posedge aclk) begin
        if (take) begin
            frame_reg <= frame_next;
        end
    end

    assign frame_valid = in_valid_reg;
    assign frame       = frame_reg;

endmodule

// File: rtl/ccpd_decode.sv
module ccpd_decode (
    input  ccpd_pkg::frame_t  frame,
    input  ccpd_pkg::hold_t   hold,
    output ccpd_pkg::hold_t   hold_next,
    output logic              emit,
    output ccpd_pkg::result_t result
);
    import ccpd_pkg::*;

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic       left_ok;
    sign_t      left_sign;
    dir_check_t arm_chk;
    dir_check_t bucket_chk;
    hold_t      decoded;

    assign b0 = frame.data[0];
    assign b1 = frame.data[1];
    assign b2 = frame.data[2];
    assign b3 = frame.data[3];
    assign b4 = frame.data[4];
    assign b5 = frame.data[5];

    // Left stick direction: pair 5:4 wins over pair 3:2
    assign left_ok = pair_ok(b0[1:0]) && pair_ok(b0[3:2]) && pair_ok(b0[5:4]);
    always_comb begin
        if (b0[5:4] == PAIR_SET) begin
            left_sign = SIGN_POS;
        end else if (b0[3:2] == PAIR_SET) begin
            left_sign = SIGN_NEG;
        end else begin
            left_sign = SIGN_ZERO;
        end
    end

    // Right stick: bucket inherits the arm direction when byte0 is idle
    assign arm_chk    = stick_dir(b2, SIGN_ZERO);
    assign bucket_chk = stick_dir(b0, arm_chk.sign);

    // Apply the frame to the held state
    always_comb begin
        decoded = hold;
        case (frame.frame_id)
            ID_SIGNAL: begin
                decoded.front_light    = b0[4];
                decoded.back_light     = b0[3];
                if (frame.in_process) begin
                    decoded.wiper = b1[0];
                end
                decoded.resume_request = (b2 != 8'd0);
                decoded.emergency_stop = (b3 != 8'd0);
                decoded.throttle       = b4;
                decoded.brake          = b5;
                decoded.seen_mask      = hold.seen_mask | MASK_SIGNAL;
            end
            ID_LEFT: begin
                if (left_ok) begin
                    decoded.steer = apply_sign({b1, b0[7:6]}, left_sign);
                    if (b5[5:4] == PAIR_SET) begin
                        decoded.gear = GEAR_DRIVE;
                    end else if (b5[7:6] == PAIR_SET) begin
                        decoded.gear = GEAR_REVERSE;
                    end else begin
                        decoded.gear = GEAR_NEUTRAL;
                    end
                    decoded.seen_mask = hold.seen_mask | MASK_LEFT;
                end
            end
            ID_RIGHT: begin
                if (arm_chk.ok) begin
                    decoded.arm = apply_sign({b3, b2[7:6]}, arm_chk.sign);
                    if (bucket_chk.ok) begin
                        decoded.bucket    = apply_sign({b1, b0[7:6]}, bucket_chk.sign);
                        decoded.seen_mask = hold.seen_mask | MASK_RIGHT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Emit at end of an in-process batch once all three frame types are in
    assign emit = frame.last_in_batch && frame.in_process
                  && (decoded.seen_mask == MASK_ALL);

    always_comb begin
        hold_next = decoded;
        if (emit) begin
            hold_next.seen_mask = 3'b000;
        end
    end

    always_comb begin
        result.steer          = decoded.steer;
        result.arm            = decoded.arm;
        result.bucket         = decoded.bucket;
        result.throttle       = decoded.throttle;
        result.brake          = decoded.brake;
        result.gear           = decoded.gear;
        result.front_light    = decoded.front_light;
        result.back_light     = decoded.back_light;
        result.wiper          = decoded.wiper;
        result.emergency_stop = decoded.emergency_stop;
        result.resume_request = decoded.resume_request;
    end

endmodule

// File: rtl/ccpd_out_stage.sv
module ccpd_out_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  ccpd_pkg::result_t               result,
    output logic                            can_load,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // steer[10:0], arm[21:11], bucket[32:22], throttle[40:33], brake[48:41],
    // gear[50:49], front_light[51], back_light[52], wiper[53],
    // emergency_stop[54], resume_request[55]
    output logic [ccpd_pkg::M_DATA_W-1:0]   m_tdata
);
    import ccpd_pkg::*;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;

    // Free when empty or when the held word is taken this cycle
    assign can_load = !out_valid_reg || m_tready;

    // Pack the record, first field lowest
    always_comb begin
        out_data_next = {result.resume_request, result.emergency_stop, result.wiper,
                         result.back_light, result.front_light, result.gear,
                         result.brake, result.throttle, result.bucket,
                         result.arm, result.steer};
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: rtl/can_control_panel_decoder_unit.sv
// An accepted frame is decoded from the input register and its record, if any, is
// loaded into the result register. Throughput: one frame per cycle while the result side
// is not stalled, set by the single decode stage between input and result registers.
// Reset: synchronous, active low; clears the valid flags, the seen mask and all held
// command values (gear neutral).
module can_control_panel_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // frame_id[11:0], byte0[19:12], byte1[27:20], byte2[35:28], byte3[43:36],
    // byte4[51:44], byte5[59:52], zero pad [63:60]
    input  logic [ccpd_pkg::S_DATA_W-1:0]   s_tdata,
    // in_process
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // steer[10:0], arm[21:11], bucket[32:22], throttle[40:33], brake[48:41],
    // gear[50:49], front_light[51], back_light[52], wiper[53],
    // emergency_stop[54], resume_request[55]
    output logic [ccpd_pkg::M_DATA_W-1:0]   m_tdata
);
    import ccpd_pkg::*;

    logic    frame_valid;
    frame_t  frame;
    logic    advance;
    logic    can_load;
    logic    emit;
    result_t result;
    hold_t   hold_reg;
    hold_t   hold_next;

    // Move the held frame through decode when the result side has room
    assign advance = frame_valid && can_load;

    ccpd_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .advance     (advance),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    ccpd_decode u_decode (
        .frame     (frame),
        .hold      (hold_reg),
        .hold_next (hold_next),
        .emit      (emit),
        .result    (result)
    );

    // Update held commands once per decoded frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (advance) begin
            hold_reg <= hold_next;
        end
    end

    ccpd_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && emit),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/ccpd_checker.sv
module ccpd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ccpd_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ccpd_pkg::M_DATA_W-1:0]   m_tdata
);
    import ccpd_pkg::*;

    // Reset empties both stages
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("stages not empty after reset");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // Gear is never the unused code
    a_gear_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50:49] != 2'd3))
        else $error("gear field out of range");

    // Signed axes stay within plus or minus 1023
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[10:0] != 11'h400) && (m_tdata[21:11] != 11'h400)
                      && (m_tdata[32:22] != 11'h400)))
        else $error("axis field out of range");

endmodule

bind can_control_panel_decoder_unit ccpd_checker u_ccpd_checker (.*);

// File: test/tb.sv
module tb;
    import ccpd_pkg::*;

    // Result word as it sits on m_tdata, highest field first
    typedef struct packed {
        logic               resume_request;
        logic               emergency_stop;
        logic               wiper;
        logic               back_light;
        logic               front_light;
        gear_t              gear;
        logic signed [7:0]  brake;
        logic signed [7:0]  throttle;
        logic signed [10:0] bucket;
        logic signed [10:0] arm;
        logic signed [10:0] steer;
    } cmd_word_t;

    // Tracks the held command values and the records they should produce
    class panel_decode_board;
        logic [2:0]  seen;
        logic [10:0] steer, arm, bucket;
        logic [7:0]  throttle, brake;
        gear_t       gear;
        logic        front, back, wiper, emerg, resume;
        cmd_word_t   awaited_cmds[$];
        int          mismatches;

        function new();
            seen = '0;
            steer = '0;
            arm = '0;
            bucket = '0;
            throttle = '0;
            brake = '0;
            gear = GEAR_NEUTRAL;
            {front, back, wiper, emerg, resume} = '0;
            mismatches = 0;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 60)
                $display("MISMATCH: %s", msg);
        endtask

        // 10-bit magnitude times direction, 11-bit two's complement
        function logic [10:0] scaled(logic [9:0] mag, sign_t s);
            case (s)
                SIGN_POS: return {1'b0, mag};
                SIGN_NEG: return 11'd0 - {1'b0, mag};
                default:  return 11'd0;
            endcase
        endfunction

        // Pair 3:2 wins over pair 5:4; a set pair that is not 01 rejects
        function bit stick_dir(logic [7:0] b, inout sign_t s);
            if (b[3:2] != PAIR_IDLE) begin
                if (b[3:2] != PAIR_SET) return 1'b0;
                s = SIGN_NEG;
            end else if (b[5:4] != PAIR_IDLE) begin
                if (b[5:4] != PAIR_SET) return 1'b0;
                s = SIGN_POS;
            end
            return 1'b1;
        endfunction

        function void note_frame(frame_t f);
            logic [1:0] p0, p2, p4;
            sign_t      s;
            cmd_word_t  rec;
            s = SIGN_ZERO;
            p0 = f.data[0][1:0];
            p2 = f.data[0][3:2];
            p4 = f.data[0][5:4];
            if (f.frame_id == ID_SIGNAL) begin
                front = f.data[0][4];
                back = f.data[0][3];
                if (f.in_process)
                    wiper = f.data[1][0];
                resume = (f.data[2] != 8'd0);
                emerg = (f.data[3] != 8'd0);
                throttle = f.data[4];
                brake = f.data[5];
                seen |= MASK_SIGNAL;
            end else if (f.frame_id == ID_LEFT) begin
                if ((p0 == PAIR_IDLE || p0 == PAIR_SET) && (p2 == PAIR_IDLE || p2 == PAIR_SET)
                        && (p4 == PAIR_IDLE || p4 == PAIR_SET)) begin
                    if (p2 == PAIR_SET) s = SIGN_NEG;
                    if (p4 == PAIR_SET) s = SIGN_POS;
                    steer = scaled({f.data[1], f.data[0][7:6]}, s);
                    if (f.data[5][5:4] == PAIR_SET)
                        gear = GEAR_DRIVE;
                    else if (f.data[5][7:6] == PAIR_SET)
                        gear = GEAR_REVERSE;
                    else
                        gear = GEAR_NEUTRAL;
                    seen |= MASK_LEFT;
                end
            end else if (f.frame_id == ID_RIGHT) begin
                // arm lands even when the bucket byte is rejected
                if (stick_dir(f.data[2], s)) begin
                    arm = scaled({f.data[3], f.data[2][7:6]}, s);
                    if (stick_dir(f.data[0], s)) begin
                        bucket = scaled({f.data[1], f.data[0][7:6]}, s);
                        seen |= MASK_RIGHT;
                    end
                end
            end
            // Emit at end of a complete batch while in process
            if (f.last_in_batch && f.in_process && seen == MASK_ALL) begin
                rec.steer = steer;
                rec.arm = arm;
                rec.bucket = bucket;
                rec.throttle = throttle;
                rec.brake = brake;
                rec.gear = gear;
                rec.front_light = front;
                rec.back_light = back;
                rec.wiper = wiper;
                rec.emergency_stop = emerg;
                rec.resume_request = resume;
                awaited_cmds.push_back(rec);
                seen = '0;
            end
        endfunction

        task cmp(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_record(logic [M_DATA_W-1:0] word);
            cmd_word_t got, want;
            got = cmd_word_t'(word);
            if (awaited_cmds.size() == 0) begin
                report($sformatf("unexpected record %h", word));
                return;
            end
            want = awaited_cmds.pop_front();
            if ($isunknown(word))
                report($sformatf("unknown bits in record %h", word));
            cmp("steer", got.steer, want.steer);
            cmp("arm", got.arm, want.arm);
            cmp("bucket", got.bucket, want.bucket);
            cmp("throttle", got.throttle, want.throttle);
            cmp("brake", got.brake, want.brake);
            cmp("gear", got.gear, want.gear);
            cmp("front_light", got.front_light, want.front_light);
            cmp("back_light", got.back_light, want.back_light);
            cmp("wiper", got.wiper, want.wiper);
            cmp("emergency_stop", got.emergency_stop, want.emergency_stop);
            cmp("resume_request", got.resume_request, want.resume_request);
        endtask
    endclass

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_FRAMES = 400;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    panel_decode_board board;
    bit                no_idle;
    int                cycles;

    can_control_panel_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 33);
    end

    // Check each record word on the falling edge ahead of its handshake edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_record(m_tdata);
    end

    function automatic frame_t make_frame(logic [11:0] id, logic [7:0] b0, logic [7:0] b1,
                                          logic [7:0] b2, logic [7:0] b3, logic [7:0] b4,
                                          logic [7:0] b5, bit ip, bit lst);
        frame_t f;
        f.frame_id = id;
        f.data = {b5, b4, b3, b2, b1, b0};
        f.in_process = ip;
        f.last_in_batch = lst;
        return f;
    endfunction

    // Present one word, hold it until taken, then maybe idle a while
    task send_frame(frame_t f);
        bit taken;
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, f.data, f.frame_id};
        s_tuser <= f.in_process;
        s_tlast <= f.last_in_batch;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            if (taken)
                board.note_frame(f);
            @(posedge aclk);
        end
        if (!no_idle && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < 33);
        end
    endtask

    // Byte whose three direction pairs are each idle or set
    function automatic logic [7:0] clean_dir(logic [1:0] top);
        logic [7:0] b;
        b = {top, 6'b0};
        b[1:0] = $urandom_range(0, 1) ? PAIR_SET : PAIR_IDLE;
        b[3:2] = $urandom_range(0, 1) ? PAIR_SET : PAIR_IDLE;
        b[5:4] = $urandom_range(0, 1) ? PAIR_SET : PAIR_IDLE;
        return b;
    endfunction

    task random_frame(logic [11:0] id, bit ip, bit lst);
        logic [7:0] b[6];
        int         k;
        for (k = 0; k < 6; k++)
            b[k] = 8'($urandom_range(0, 255));
        // Mostly well-formed directions, the rest raw noise
        if ($urandom_range(0, 99) < 85) begin
            if (id == ID_LEFT)
                b[0] = clean_dir(b[0][7:6]);
            if (id == ID_RIGHT) begin
                b[0] = clean_dir(b[0][7:6]);
                b[2] = clean_dir(b[2][7:6]);
            end
        end
        send_frame(make_frame(id, b[0], b[1], b[2], b[3], b[4], b[5], ip, lst));
    endtask

    initial begin
        int         sent, n, k, r;
        bit         ip, lst;
        logic [11:0] id;
        board = new();
        no_idle = 1'b0;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full-scale values, both signs, drive gear, then a record
        send_frame(make_frame(ID_SIGNAL, 8'h18, 8'h01, 8'hFF, 8'h01, 8'h7F, 8'h80, 1, 0));
        send_frame(make_frame(ID_LEFT, 8'hD0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h10, 1, 0));
        send_frame(make_frame(ID_RIGHT, 8'hC0, 8'hFF, 8'hC4, 8'hFF, 8'h00, 8'h00, 1, 1));
        // Incomplete set, then out of process: no record, wiper kept
        send_frame(make_frame(ID_SIGNAL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7F, 1, 1));
        send_frame(make_frame(ID_SIGNAL, 8'hE7, 8'h01, 8'h00, 8'h80, 8'h01, 8'hFE, 0, 1));
        // Left rejects on each pair
        send_frame(make_frame(ID_LEFT, 8'h02, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h10, 1, 0));
        send_frame(make_frame(ID_LEFT, 8'h0C, 8'h55, 8'h00, 8'h00, 8'h00, 8'h40, 1, 0));
        send_frame(make_frame(ID_LEFT, 8'h20, 8'h11, 8'h00, 8'h00, 8'h00, 8'h40, 1, 0));
        // Both pairs set: positive wins; reverse gear
        send_frame(make_frame(ID_LEFT, 8'h55, 8'h80, 8'h00, 8'h00, 8'h00, 8'h40, 1, 0));
        // Right: partial reject updates arm only
        send_frame(make_frame(ID_RIGHT, 8'h08, 8'h33, 8'h50, 8'h80, 8'h00, 8'h00, 1, 0));
        // Right rejected on the arm byte
        send_frame(make_frame(ID_RIGHT, 8'h00, 8'h00, 8'h30, 8'h7F, 8'h00, 8'h00, 1, 0));
        // Bucket keeps arm sign when its pairs idle; ignored ids close the batch
        send_frame(make_frame(ID_RIGHT, 8'h80, 8'h01, 8'h44, 8'h02, 8'h00, 8'h00, 1, 0));
        send_frame(make_frame(12'hFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 0));
        send_frame(make_frame(12'h000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1));
        // Zero sign, both gear pairs 11 give neutral; data with pair 11 at 5:4
        send_frame(make_frame(ID_LEFT, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 1, 0));
        send_frame(make_frame(ID_RIGHT, 8'h34, 8'hFF, 8'h18, 8'h00, 8'h00, 8'h00, 1, 0));
        send_frame(make_frame(ID_RIGHT, 8'h14, 8'h00, 8'h90, 8'hC3, 8'h00, 8'h00, 1, 0));
        send_frame(make_frame(ID_SIGNAL, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0));
        send_frame(make_frame(12'h182, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1));
        // Gear drive beats reverse
        send_frame(make_frame(ID_LEFT, 8'h04, 8'h01, 8'h00, 8'h00, 8'h00, 8'h50, 1, 0));
        send_frame(make_frame(ID_SIGNAL, 8'h08, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0));
        send_frame(make_frame(ID_RIGHT, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1, 1));

        // Random batches of mostly decodable frames
        sent = 0;
        while (sent < RANDOM_FRAMES) begin
            n = $urandom_range(1, 6);
            ip = ($urandom_range(0, 99) < 90);
            for (k = 0; k < n; k++) begin
                no_idle = (sent >= 150 && sent < 250);
                r = $urandom_range(0, 99);
                if (r < 30)
                    id = ID_SIGNAL;
                else if (r < 60)
                    id = ID_LEFT;
                else if (r < 90)
                    id = ID_RIGHT;
                else
                    id = 12'($urandom_range(0, 4095));
                if (k == n - 1)
                    lst = ($urandom_range(0, 99) < 90);
                else
                    lst = ($urandom_range(0, 99) < 5);
                if ($urandom_range(0, 99) < 5)
                    ip = ~ip;
                random_frame(id, ip, lst);
                if (id == ID_SIGNAL || id == ID_LEFT || id == ID_RIGHT)
                    sent++;
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // Drain outstanding records, then allow the pipeline to settle
        while (board.awaited_cmds.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (board.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
